/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/caf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package caf_pkg;
  localparam int CordicSteps = 16;
  localparam int DeltaWidth  = 16;
  localparam int AtanEntries = 24;
  localparam int CordicUsed  = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

  localparam logic [1:0] AddrBlend = 2'd0;
  localparam logic [1:0] AddrGain  = 2'd1;
  localparam logic [1:0] AddrNorm  = 2'd2;

  // Sample as held in the queue between front and back.
  typedef struct packed {
    logic               first;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gz;
    logic [DeltaWidth-1:0] ticks;
  } caf_item_t;

  typedef struct packed {
    logic [16:0] blend;
    logic [23:0] gain;
    logic [31:0] norm;
  } caf_cfg_t;

  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
      5'd3: r = 22'd466945;   5'd4: r = 22'd234379;   5'd5: r = 22'd117305;
      5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
      5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
      5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
      5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
      5'd21: r = 22'd2;       5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/caf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module caf_front import caf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [111:0] in_data,
  output logic           q_valid,
  input  wire logic      q_ready,
  output caf_item_t      q_item
);
  logic        started_r;
  logic [31:0] last_r;
  caf_item_t   slot_r [2];
  logic [1:0]  cnt_r;
  logic        wp_r, rp_r;
  logic [31:0] diff;
  caf_item_t   it;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = slot_r[rp_r];
  assign diff = in_data[111:80] - last_r;

  always_comb begin
    it.first = !started_r;
    it.ax = in_data[15:0];
    it.ay = in_data[31:16];
    it.az = in_data[47:32];
    it.gx = in_data[63:48];
    it.gz = in_data[79:64];
    if (diff > 32'((64'd1 << DeltaWidth) - 64'd1)) begin
      it.ticks = '1;
    end else begin
      it.ticks = diff[DeltaWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      last_r <= '0;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= it;
        wp_r <= !wp_r;
        started_r <= 1'b1;
        last_r <= in_data[111:80];
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/caf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module caf_back import caf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  caf_item_t  q_item,
  input  caf_cfg_t   cfg,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [31:0] out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQRT, S_PRE, S_CORDIC, S_GYRO1, S_GYRO2, S_GYRO3,
    S_BL1, S_BL2, S_NEXT, S_OUT
  } st_t;

  st_t st_r;
  caf_item_t  it_r;
  logic signed [31:0] pest_r, yest_r;
  logic [31:0] rem_r, root_r, bit_r;
  logic [4:0]  cnt_r;
  logic        ch_r;               // 0 pitch, 1 yaw
  logic signed [40:0] x_r, y_r, z_r;
  logic [39:0] p_r;                // |rate|*gain
  logic [63:0] m_r;
  logic        neg_r;
  logic signed [33:0] g_r;
  logic signed [33:0] acc_r;
  logic signed [51:0] s1_r;
  logic [31:0] out_data_r;
  logic        out_valid_r;

  logic [31:0] sqa, sqb, sqc;
  logic [16:0] aw;
  logic signed [40:0] sx, sy;
  logic [32:0] sum1;
  logic [79:0] mprod;
  logic signed [64:0] dsig;
  logic signed [65:0] gdiff;
  logic signed [84:0] ssum;
  logic signed [68:0] shf;
  logic signed [33:0] est_sel;
  logic signed [16:0] arg_y, arg_x;

  function automatic logic [15:0] to_out(input logic signed [31:0] e);
    logic signed [32:0] v;
    logic signed [23:0] q;
    v = 33'(e) + 33'sd256;
    q = 24'(v >>> 9);
    if (q > 24'sd32767) return 16'h7fff;
    else if (q < -24'sd32768) return 16'h8000;
    else return q[15:0];
  endfunction

  assign q_ready = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign sqa = it_r.ax * it_r.ax;
  assign sqb = it_r.ay * it_r.ay;
  assign sqc = it_r.az * it_r.az;
  assign aw = (cfg.blend > 17'd65536) ? 17'd65536 : cfg.blend;
  assign sx = x_r >>> cnt_r;
  assign sy = y_r >>> cnt_r;
  assign sum1 = {1'b0, root_r} + {1'b0, bit_r};
  assign mprod = p_r * {{(80-40-DeltaWidth){1'b0}}, it_r.ticks};
  assign est_sel = ch_r ? 34'(yest_r) : 34'(pest_r);
  assign dsig = neg_r ? -65'((m_r + 64'd128) >> 8) : 65'((m_r + 64'd128) >> 8);
  assign gdiff = 66'(est_sel) - 66'(dsig);
  assign ssum = 85'(s1_r) + 85'(52'($signed({1'b0, aw})) * 52'(acc_r)) + 85'sd32768;
  assign shf = 69'(ssum >>> 16);
  // pitch: atan2(-az, root); yaw: atan2(ax, -ay); 17 bits hold a negated -32768
  assign arg_y = ch_r ? 17'(it_r.ax) : -17'(it_r.az);
  assign arg_x = ch_r ? -17'(it_r.ay) : {1'b0, root_r[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pest_r <= '0;
      yest_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && st_r != S_OUT) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          st_r <= q_item.first ? S_IDLE : S_NORM;
        end
        S_NORM: begin
          rem_r <= sqa + sqb;
          root_r <= '0;
          bit_r <= 32'h4000_0000;
          ch_r <= 1'b0;
          if ({1'b0, sqa + sqb} + {1'b0, sqc} > {1'b0, cfg.norm}) st_r <= S_SQRT;
          else st_r <= S_NEXT;
        end
        S_SQRT: begin
          // one result bit per cycle
          if (bit_r == '0) begin
            st_r <= S_PRE;
          end else begin
            if ({1'b0, rem_r} >= sum1) begin
              rem_r <= rem_r - sum1[31:0];
              root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_PRE: begin
          if (arg_x == '0 && arg_y == '0) begin
            x_r <= '0; y_r <= '0; z_r <= '0;
            cnt_r <= 5'(CordicUsed);
          end else if (arg_x[16]) begin
            cnt_r <= '0;
            if (!arg_y[16]) begin
              x_r <= 41'(arg_y) <<< 16; y_r <= -(41'(arg_x) <<< 16);
              z_r <= 41'sd5898240;
            end else begin
              x_r <= -(41'(arg_y) <<< 16); y_r <= 41'(arg_x) <<< 16;
              z_r <= -41'sd5898240;
            end
          end else begin
            cnt_r <= '0;
            x_r <= 41'(arg_x) <<< 16; y_r <= 41'(arg_y) <<< 16; z_r <= '0;
          end
          st_r <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cnt_r == 5'(CordicUsed)) begin
            p_r <= 40'(ch_r ? (it_r.gz[15] ? -17'(it_r.gz) : 17'(it_r.gz))
                            : (it_r.gx[15] ? -17'(it_r.gx) : 17'(it_r.gx))) * 40'(cfg.gain);
            neg_r <= ch_r ? it_r.gz[15] : it_r.gx[15];
            acc_r <= 34'(z_r);
            st_r <= S_GYRO1;
          end else begin
            if (y_r > 0) begin
              x_r <= x_r + sy; y_r <= y_r - sx; z_r <= z_r + 41'($signed({1'b0, atan_lut(cnt_r)}));
            end else begin
              x_r <= x_r - sy; y_r <= y_r + sx; z_r <= z_r - 41'($signed({1'b0, atan_lut(cnt_r)}));
            end
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_GYRO1: begin
          // p < 2^40 and ticks < 2^DeltaWidth, so limit only matters above 2^62
          m_r <= (mprod > (80'd1 << 62)) ? (64'd1 << 62) : mprod[63:0];
          st_r <= S_GYRO2;
        end
        S_GYRO2: begin
          if (gdiff > 66'sh7fffffff) g_r <= 34'sh7fffffff;
          else if (gdiff < -66'sh80000000) g_r <= -34'sh80000000;
          else g_r <= gdiff[33:0];
          st_r <= S_BL1;
        end
        S_BL1: begin
          s1_r <= 52'($signed({1'b0, 17'd65536 - aw})) * 52'(g_r);
          st_r <= S_BL2;
        end
        S_BL2: begin
          if (ch_r) begin
            yest_r <= (shf > 69'sh7fffffff) ? 32'sh7fffffff :
                      (shf < -69'sh80000000) ? -32'sh80000000 : shf[31:0];
            st_r <= S_NEXT;
          end else begin
            pest_r <= (shf > 69'sh7fffffff) ? 32'sh7fffffff :
                      (shf < -69'sh80000000) ? -32'sh80000000 : shf[31:0];
            ch_r <= 1'b1;
            st_r <= S_PRE;
          end
        end
        S_NEXT: st_r <= S_OUT;
        S_OUT: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          out_data_r <= {to_out(yest_r), to_out(pest_r)};
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/caf_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module caf_regs import caf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output caf_cfg_t         cfg
);
  caf_cfg_t cfg_r;
  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign cfg = cfg_r;

  always_comb begin
    case (idx)
      AddrBlend: prdata = {15'd0, cfg_r.blend};
      AddrGain:  prdata = {8'd0, cfg_r.gain};
      AddrNorm:  prdata = cfg_r.norm;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend <= 17'd1311;
      cfg_r.gain <= '0;
      cfg_r.norm <= 32'd2683044;
    end else if (psel && penable && pwrite) begin
      case (idx)
        AddrBlend: cfg_r.blend <= pwdata[16:0];
        AddrGain:  cfg_r.gain <= pwdata[23:0];
        AddrNorm:  cfg_r.norm <= pwdata;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/complementary_attitude_filter.sv */
// Complementary attitude filter: accelerometer plus gyro pitch and yaw.
// Input stream: one IMU sample per transfer. Output stream: one transfer
// with both angles per sample, except the first sample after reset, which
// only records its timestamp.
// Config: APB-style registers blend_weight (0x0), gyro_gain (0x4) and
// min_norm_squared (0x8); write them only while the block is idle.
// A front stage computes elapsed ticks and parks samples in a two-entry
// queue; the back engine works one sample at a time: norm check, a
// 16-step square root, then per angle a CORDIC (16 steps, none when both
// atan2 arguments are zero) with gyro and blend steps; below the threshold
// only the norm check runs and the held estimates go out. The sequential
// CORDIC and root loops set the time taken per sample; the queue is registered.
// Reset clears estimates, timestamp and the started flag and loads the
// register defaults. When out_tready is low the result holds in the output
// register; the back engine goes on with the next sample and waits once its
// result is ready, so the queue absorbs two samples before in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module complementary_attitude_filter import caf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // accel_x, accel_y, accel_z, gyro_x_rate, gyro_z_rate, sample_time
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pitch_out, yaw_out
  output logic [31:0]       out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  caf_cfg_t  cfg;
  caf_item_t q_item;
  logic      q_valid, q_ready;

  assign cfg_pready = 1'b1;

  caf_regs u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cfg
  );

  caf_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .q_valid, .q_ready, .q_item
  );

  caf_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item, .cfg,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata)
  );

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_IMPLIES(a_pready, clk, rst_n, 1'b1, cfg_pready, "pready low")
endmodule
`default_nettype wire

/* dv/caf_checker.sv */
`timescale 1ns / 1ps
module caf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [111:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_angles
);
  import caf_pkg::*;

  localparam longint I32Min = -64'sd2147483648;
  localparam longint I32Max = 64'sd2147483647;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angle_pair_t;

  angle_pair_t angle_q[$];

  longint pitch_est, yaw_est;
  logic [31:0] prev_stamp;
  logic        have_stamp;
  logic [16:0] alpha;
  logic [23:0] gain;
  logic [31:0] norm_floor;

  longint atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  function automatic longint vector_angle(longint yin, longint xin);
    longint x, y, z, t;
    x = xin * 65536;
    y = yin * 65536;
    z = 0;
    if (xin == 0 && yin == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CordicUsed; i++) begin
      t = x;
      if (y > 0) begin
        x += floor_sh(y, i); y -= floor_sh(t, i); z += atan_steps[i];
      end else begin
        x -= floor_sh(y, i); y += floor_sh(t, i); z -= atan_steps[i];
      end
    end
    return z;
  endfunction

  function automatic longint gyro_angle(longint est, longint rate, longint ticks);
    logic [63:0] prod, mag, lim;
    longint d;
    prod = (rate < 0 ? -rate : rate) * longint'(gain);
    lim = 64'd1 << 62;
    if (ticks != 0 && prod > lim / ticks) mag = lim;
    else mag = prod * ticks;
    d = longint'((mag + 64'd128) >> 8);
    if (rate < 0) d = -d;
    return clip(est - d, I32Min, I32Max);
  endfunction

  function automatic longint mix(longint g, longint acc);
    longint a;
    a = alpha > 17'd65536 ? 65536 : longint'(alpha);
    return clip(floor_sh((65536 - a) * g + a * acc + 32768, 16), I32Min, I32Max);
  endfunction

  function automatic logic [15:0] to_deg128(longint est);
    return 16'(clip(floor_sh(est + 256, 9), -32768, 32767));
  endfunction

  // Advance the filter state for one accepted sample.
  task automatic absorb_sample(logic [111:0] d);
    longint ax, ay, az, gx, gz, ticks, mag2, gp, gy;
    logic [31:0] stamp;
    angle_pair_t res;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gz = longint'($signed(d[79:64]));
    stamp = d[111:80];
    if (!have_stamp) begin
      have_stamp = 1'b1;
      prev_stamp = stamp;
      return;
    end
    ticks = longint'(stamp - prev_stamp);
    if (ticks > (1 << DeltaWidth) - 1) ticks = (1 << DeltaWidth) - 1;
    mag2 = ax * ax + ay * ay + az * az;
    if (mag2 > longint'(norm_floor)) begin
      gp = gyro_angle(pitch_est, gx, ticks);
      gy = gyro_angle(yaw_est, gz, ticks);
      pitch_est = mix(gp, vector_angle(-az, root_floor(ax * ax + ay * ay)));
      yaw_est = mix(gy, vector_angle(ax, -ay));
    end
    prev_stamp = stamp;
    res.pitch = to_deg128(pitch_est);
    res.yaw = to_deg128(yaw_est);
    angle_q.push_back(res);
  endtask

  always @(posedge clk) begin
    angle_pair_t want;
    if (!rst_n) begin
      pitch_est = 0; yaw_est = 0; prev_stamp = '0; have_stamp = 1'b0;
      alpha = 17'd1311; gain = '0; norm_floor = 32'd2683044;
      angle_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          AddrBlend: alpha = cfg_pwdata[16:0];
          AddrGain:  gain = cfg_pwdata[23:0];
          AddrNorm:  norm_floor = cfg_pwdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = angle_q.pop_front();
          if (want.pitch !== out_tdata[15:0] || want.yaw !== out_tdata[31:16]) begin
            $display("%0t: expected pitch %0d yaw %0d, got pitch %0d yaw %0d", $time,
              want.pitch, want.yaw, $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) absorb_sample(in_tdata);
    end
    pending_angles <= angle_q.size();
  end
endmodule

/* dv/tb_complementary_attitude_filter.sv */
`timescale 1ns / 1ps
module tb_complementary_attitude_filter;
  import caf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // accel_x, accel_y, accel_z, gyro_x_rate, gyro_z_rate, sample_time
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // pitch_out, yaw_out
  logic [31:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending_angles;
  int send_idle_pct = 0, take_idle_pct = 0;
  longint cycle_count = 0;
  logic [31:0] clock_ticks = 32'd0;

  always #5 clk = ~clk;

  complementary_attitude_filter i_dut (.*);

  caf_checker i_checker (.*);

  // Stop the run if something hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Randomly stall the result side.
  always @(negedge clk) out_tready <= ($urandom_range(99) >= take_idle_pct);

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Hold the sample until it is accepted; idle beforehand at random.
  // Valid stays high after the transfer until the next sample or an idle.
  task automatic send_sample(logic [15:0] ax, ay, az, gx, gz, logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {stamp, gz, gx, az, ay, ax};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all results, then let the engine settle before touching registers.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_angles != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Mostly plausible gravity vectors, sometimes full-range noise.
  task automatic random_sample();
    logic [15:0] ax, ay, az;
    int mode;
    mode = $urandom_range(9);
    if (mode < 6) begin
      ax = 16'($signed($urandom_range(16000)) - 8000);
      ay = 16'($signed($urandom_range(16000)) - 8000);
      az = 16'($signed($urandom_range(16000)) - 8000);
    end else if (mode < 8) begin
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
    end else begin
      ax = 16'($signed($urandom_range(1000)) - 500);
      ay = 16'($signed($urandom_range(1000)) - 500);
      az = 16'($signed($urandom_range(1000)) - 500);
    end
    if ($urandom_range(19) == 0) clock_ticks = $urandom;
    else clock_ticks = clock_ticks + $urandom_range(200);
    send_sample(ax, ay, az, 16'($urandom), 16'($urandom), clock_ticks);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first sample only records time, then extremes and corner cases.
    send_sample(16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFF0);
    send_sample(16'd0, 16'd16384, 16'd0, 16'd100, 16'd0, 32'h0000_0010);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h0010_0000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
    send_sample(16'd0, 16'd0, 16'd3000, 16'd0, 16'd0, 32'd0);
    send_sample(16'd0, 16'd0, 16'hF000, 16'd0, 16'd0, 32'd5);
    send_sample(16'd10, 16'd10, 16'd10, 16'd0, 16'd0, 32'd6);
    send_sample(16'hC000, 16'h4000, 16'd0, 16'd1, 16'hFFFF, 32'd9);
    send_sample(16'hC000, 16'hC000, 16'd0, 16'd1, 16'hFFFF, 32'd9);
    wait_idle();
    write_reg(AddrBlend, 32'd0);
    write_reg(AddrGain, 32'hFF_FFFF);
    write_reg(AddrNorm, 32'd0);
    send_sample(16'd0, 16'd0, 16'd1, 16'h7FFF, 16'h8000, 32'd70000);
    send_sample(16'd0, 16'd0, 16'd1, 16'h8000, 16'h7FFF, 32'd200000);
    send_sample(16'd1, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 32'd200001);
    wait_idle();
    write_reg(AddrBlend, 32'h1_FFFF);
    write_reg(AddrNorm, 32'hFFFF_FFFF);
    send_sample(16'd0, 16'hC000, 16'd0, 16'd5, 16'd5, 32'd200100);
    wait_idle();
    write_reg(AddrNorm, 32'd1000);
    send_sample(16'd0, 16'hC000, 16'd100, 16'd5, 16'd5, 32'd200200);
    send_sample(16'd100, 16'd0, 16'd0, 16'd5, 16'd5, 32'd200300);

    // Random phases: sender mostly busy, then receiver mostly busy, then flat out.
    clock_ticks = 32'd200300;
    for (int phase = 0; phase < 9; phase++) begin
      wait_idle();
      case (phase % 3)
        0: begin send_idle_pct = 22; take_idle_pct = 77; end
        1: begin send_idle_pct = 77; take_idle_pct = 22; end
        default: begin send_idle_pct = 0; take_idle_pct = 0; end
      endcase
      write_reg(AddrBlend, phase == 8 ? 32'd65536 : $urandom_range(65536));
      write_reg(AddrGain, phase == 4 ? 32'd0 : $urandom_range(24'hFF_FFFF));
      write_reg(AddrNorm, phase == 5 ? 32'd0 : $urandom_range(4000000));
      for (int n = 0; n < 148; n++) begin
        random_sample();
        if (n == 70 && phase == 2) wait_idle();
      end
    end

    wait_idle();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/caf_pkg.sv
rtl/caf_front.sv
rtl/caf_back.sv
rtl/caf_regs.sv
rtl/complementary_attitude_filter.sv
dv/caf_checker.sv
dv/tb_complementary_attitude_filter.sv
